### hw/rtl/bb3_pkg.sv
package bb3_pkg;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;

    // floor(x / 9) == (x * DIV9_MUL) >> 16 for every x below 2296
    localparam logic [12:0] DIV9_MUL = 13'd7282;

    localparam int NUM_KINDS = 4;
    localparam int NUM_CH    = 4;

    typedef logic [11:0] sum_t;

    typedef struct packed {
        sum_t [NUM_KINDS-1:0][NUM_CH-1:0] sums;
        logic [11:0]                      row;
        logic [10:0]                      col;
        logic [NUM_KINDS-1:0]             kinds;
        logic                             frame_end;
    } job_t;

endpackage

### hw/rtl/bb3_front.sv
module bb3_front #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_stall,
    input  logic [7:0]   pix_red,
    input  logic [7:0]   pix_green,
    input  logic [7:0]   pix_blue,
    input  logic [7:0]   pix_alpha,
    input  logic         cfg_valid,
    input  logic [1:0]   cfg_index,
    input  logic [11:0]  cfg_data,
    input  logic         q_full,
    output logic         push,
    output bb3_pkg::job_t push_job
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = CW + 1;

    logic [11:0] width_reg;
    logic [11:0] height_reg;
    logic [CW-1:0] col_reg;
    logic [11:0] row_reg;

    logic [31:0] upper_mem [MAX_WIDTH];
    logic [31:0] middle_mem [MAX_WIDTH];
    logic [31:0] up_rd_reg;
    logic [31:0] mid_rd_reg;

    logic          s1_valid_reg;
    logic [31:0]   s1_pix_reg;
    logic [CW-1:0] s1_col_reg;
    logic [11:0]   s1_row_reg;
    logic          s1_last_col_reg;
    logic          s1_last_row_reg;

    logic [2:0][2:0][31:0] win_reg;
    logic [2:0][2:0][31:0] win_next;

    logic [WW-1:0] eff_w;
    logic [11:0]   eff_h;
    logic          accept;
    logic          advance;
    logic          cfg_hit;
    logic          last_col;
    logic          last_row;
    logic [31:0]   up_g;
    logic [31:0]   mid_g;
    logic          col_nz;
    logic          row_nz;

    always_comb
    begin
        if (width_reg < 12'd2)
        begin
            eff_w = WW'(2);
        end
        else if (32'(width_reg) > MAX_WIDTH)
        begin
            eff_w = WW'(MAX_WIDTH);
        end
        else
        begin
            eff_w = WW'(width_reg);
        end
        eff_h = (height_reg < 12'd2) ? 12'd2 : height_reg;
    end

    assign cfg_hit  = cfg_valid && (cfg_index == bb3_pkg::REG_WIDTH ||
                                    cfg_index == bb3_pkg::REG_HEIGHT);
    assign in_stall = s1_valid_reg && q_full;
    assign accept   = in_valid && !in_stall;
    assign advance  = s1_valid_reg && !q_full;
    assign last_col = (WW'(col_reg) == eff_w - WW'(1));
    assign last_row = (row_reg == eff_h - 12'd1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= 12'd640;
            height_reg   <= 12'd480;
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
            win_reg      <= '0;
        end
        else if (cfg_hit)
        begin
            if (cfg_index == bb3_pkg::REG_WIDTH)
            begin
                width_reg <= cfg_data;
            end
            else
            begin
                height_reg <= cfg_data;
            end
            col_reg <= '0;
            row_reg <= '0;
            win_reg <= '0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
                if (last_col)
                begin
                    col_reg <= '0;
                    row_reg <= last_row ? 12'd0 : row_reg + 12'd1;
                end
                else
                begin
                    col_reg <= col_reg + CW'(1);
                end
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                win_reg <= win_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg      <= {pix_alpha, pix_blue, pix_green, pix_red};
            s1_col_reg      <= col_reg;
            s1_row_reg      <= row_reg;
            s1_last_col_reg <= last_col;
            s1_last_row_reg <= last_row;
            up_rd_reg       <= upper_mem[col_reg];
            mid_rd_reg      <= middle_mem[col_reg];
        end
        if (advance)
        begin
            upper_mem[s1_col_reg]  <= mid_g;
            middle_mem[s1_col_reg] <= s1_pix_reg;
        end
    end

    assign col_nz = (s1_col_reg != '0);
    assign row_nz = (s1_row_reg != 12'd0);
    // line store contents are only trusted once written in this frame
    assign up_g   = (s1_row_reg >= 12'd2) ? up_rd_reg : 32'd0;
    assign mid_g  = row_nz ? mid_rd_reg : 32'd0;

    always_comb
    begin
        if (!col_nz)
        begin
            win_next[0] = '0;
            win_next[1] = '0;
        end
        else
        begin
            win_next[0] = win_reg[1];
            win_next[1] = win_reg[2];
        end
        win_next[2] = {s1_pix_reg, mid_g, up_g};
    end

    // column sums over all three rows and over the lower two rows
    logic [2:0][3:0][9:0] col3;
    logic [2:0][3:0][9:0] col2;

    always_comb
    begin
        for (int ci = 0; ci < 3; ci++)
        begin
            for (int ch = 0; ch < 4; ch++)
            begin
                col2[ci][ch] = 10'(win_next[ci][1][8*ch +: 8]) +
                               10'(win_next[ci][2][8*ch +: 8]);
                col3[ci][ch] = col2[ci][ch] + 10'(win_next[ci][0][8*ch +: 8]);
            end
        end
        for (int ch = 0; ch < 4; ch++)
        begin
            push_job.sums[0][ch] = 12'(col3[0][ch]) + 12'(col3[1][ch]) + 12'(col3[2][ch]);
            push_job.sums[1][ch] = 12'(col3[1][ch]) + 12'(col3[2][ch]);
            push_job.sums[2][ch] = 12'(col2[0][ch]) + 12'(col2[1][ch]) + 12'(col2[2][ch]);
            push_job.sums[3][ch] = 12'(col2[1][ch]) + 12'(col2[2][ch]);
        end
        push_job.row       = s1_row_reg;
        push_job.col       = 11'(s1_col_reg);
        push_job.kinds[0]  = row_nz && col_nz;
        push_job.kinds[1]  = row_nz && s1_last_col_reg;
        push_job.kinds[2]  = s1_last_row_reg && col_nz;
        push_job.kinds[3]  = s1_last_row_reg && s1_last_col_reg;
        push_job.frame_end = s1_last_row_reg && s1_last_col_reg;
    end

    assign push = advance && (push_job.kinds != '0);

endmodule

### hw/rtl/bb3_queue.sv
module bb3_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  bb3_pkg::job_t push_job,
    output logic          full,
    input  logic          pop,
    output logic          head_valid,
    output bb3_pkg::job_t head_job
);

    bb3_pkg::job_t slot_reg [4];
    logic [1:0] head_reg;
    logic [1:0] tail_reg;
    logic [2:0] count_reg;

    assign full       = (count_reg == 3'd4);
    assign head_valid = (count_reg != 3'd0);
    assign head_job   = slot_reg[head_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                tail_reg <= tail_reg + 2'd1;
            end
            if (pop)
            begin
                head_reg <= head_reg + 2'd1;
            end
            unique case ({push, pop})
                2'b10:   count_reg <= count_reg + 3'd1;
                2'b01:   count_reg <= count_reg - 3'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[tail_reg] <= push_job;
        end
    end

endmodule

### hw/rtl/bb3_back.sv
module bb3_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          head_valid,
    input  bb3_pkg::job_t head_job,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_stall,
    output logic [7:0]    out_red,
    output logic [7:0]    out_green,
    output logic [7:0]    out_blue,
    output logic [7:0]    out_alpha,
    output logic [11:0]   out_row,
    output logic [10:0]   out_col,
    output logic          run_last,
    output logic          frame_done
);

    logic [3:0]  done_reg;
    logic        out_valid_reg;
    logic [3:0][7:0] chan_reg;
    logic [11:0] row_reg;
    logic [10:0] col_reg;
    logic        run_last_reg;
    logic        frame_done_reg;

    logic [3:0]  pending;
    logic [3:0]  sel;
    logic [1:0]  kind;
    logic        is_last;
    logic        load;
    logic [3:0][24:0] prod;

    assign pending = head_job.kinds & ~done_reg;
    assign sel     = pending & (~pending + 4'd1);
    assign is_last = ((pending & ~sel) == 4'd0);
    assign load    = head_valid && (!out_valid_reg || !out_stall);
    assign pop     = load && is_last;

    always_comb
    begin
        priority case (1'b1)
            sel[0]:  kind = 2'd0;
            sel[1]:  kind = 2'd1;
            sel[2]:  kind = 2'd2;
            default: kind = 2'd3;
        endcase
        for (int ch = 0; ch < 4; ch++)
        begin
            prod[ch] = 25'(head_job.sums[kind][ch]) * 25'(bb3_pkg::DIV9_MUL);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= 1'b1;
                done_reg      <= is_last ? 4'd0 : (done_reg | sel);
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int ch = 0; ch < 4; ch++)
            begin
                chan_reg[ch] <= prod[ch][23:16];
            end
            // upper-row results sit one row up, left results one column left
            row_reg        <= kind[1] ? head_job.row : head_job.row - 12'd1;
            col_reg        <= kind[0] ? head_job.col : head_job.col - 11'd1;
            run_last_reg   <= is_last;
            frame_done_reg <= is_last && head_job.frame_end;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_red    = chan_reg[0];
    assign out_green  = chan_reg[1];
    assign out_blue   = chan_reg[2];
    assign out_alpha  = chan_reg[3];
    assign out_row    = row_reg;
    assign out_col    = col_reg;
    assign run_last   = run_last_reg;
    assign frame_done = frame_done_reg;

endmodule

### hw/rtl/box_blur_3x3_rgba.sv
// 3x3 box blur over an rgba pixel stream in raster order
// input channel: in_valid / in_stall with pix_red, pix_green, pix_blue, pix_alpha;
//   a pixel transaction completes when in_valid is high and in_stall is low
// output channel: out_valid / out_stall with the blurred channels, out_row, out_col,
//   run_last on the last result of one pixel, frame_done on the last result of a frame
// config channel: cfg_valid / cfg_ready (always ready), cfg_index 0 = width,
//   1 = height, cfg_data; a write restarts the frame, other indexes are ignored
// each result is the 3x3 neighborhood sum divided by nine, zeros outside the image
// a pixel yields 0 to 4 results; the back end emits one per cycle unless stalled
// throughput: one pixel per cycle while each pixel yields at most one result and
//   out_stall is low; extra results at row ends and on the last row go out one at
//   a time from the back end's single result register, behind a four-entry job queue
// path: a pixel passes the stage-one registers, a job queue slot and the result
//   register before out_valid of its first result rises
// reset: counters, window and queue clear, width 640, height 480; line stores are
//   not cleared and are only used after being written in the current frame
// when out_stall is high the result holds; the queue fills, then in_stall rises
module box_blur_3x3_rgba #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  pix_red,
    input  logic [7:0]  pix_green,
    input  logic [7:0]  pix_blue,
    input  logic [7:0]  pix_alpha,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_red,
    output logic [7:0]  out_green,
    output logic [7:0]  out_blue,
    output logic [7:0]  out_alpha,
    output logic [11:0] out_row,
    output logic [10:0] out_col,
    output logic        run_last,
    output logic        frame_done,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [11:0] cfg_data
);

    logic          q_full;
    logic          push;
    bb3_pkg::job_t push_job;
    logic          pop;
    logic          head_valid;
    bb3_pkg::job_t head_job;

    assign cfg_ready = 1'b1;

    bb3_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .pix_red   (pix_red),
        .pix_green (pix_green),
        .pix_blue  (pix_blue),
        .pix_alpha (pix_alpha),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .push      (push),
        .push_job  (push_job)
    );

    bb3_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    bb3_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_red    (out_red),
        .out_green  (out_green),
        .out_blue   (out_blue),
        .out_alpha  (out_alpha),
        .out_row    (out_row),
        .out_col    (out_col),
        .run_last   (run_last),
        .frame_done (frame_done)
    );

`ifndef SYNTHESIS
    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && frame_done) |-> run_last)
        else $error("frame_done without run_last");

    a_done_row: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && frame_done) |-> (out_row != 12'd0))
        else $error("frame_done on row zero");
`endif

endmodule

### sim/tb_top.sv
module tb_top;

    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [11:0] row;
        logic [10:0] col;
        logic        last;
        logic        done;
    } blur_res_t;

    class blur_scoreboard;
        logic [31:0] upper_mem [0:2047];
        logic [31:0] middle_mem [0:2047];
        logic [31:0] win [0:8];
        int unsigned col_pos;
        int unsigned row_pos;
        int unsigned width_reg;
        int unsigned height_reg;
        blur_res_t   pending[$];
        int          mismatches;

        function void restart();
            col_pos = 0;
            row_pos = 0;
            foreach (win[i]) win[i] = '0;
        endfunction

        function void reset_state();
            width_reg = 640;
            height_reg = 480;
            mismatches = 0;
            pending.delete();
            restart();
        endfunction

        function void write_reg(logic [1:0] idx, logic [11:0] val);
            if (idx == bb3_pkg::REG_WIDTH) begin
                width_reg = val;
                restart();
            end else if (idx == bb3_pkg::REG_HEIGHT) begin
                height_reg = val;
                restart();
            end
        endfunction

        function blur_res_t window_sum(int cmask, int rmask, int unsigned r, int unsigned c);
            int unsigned acc [4];
            blur_res_t res;
            logic [31:0] p;
            for (int ch = 0; ch < 4; ch++) acc[ch] = 0;
            for (int ci = 0; ci < 3; ci++)
                for (int ri = 0; ri < 3; ri++)
                    if (cmask[ci] && rmask[ri]) begin
                        p = win[ci*3+ri];
                        for (int ch = 0; ch < 4; ch++) acc[ch] += p[8*ch +: 8];
                    end
            res.red = 8'(acc[0] / 9);
            res.green = 8'(acc[1] / 9);
            res.blue = 8'(acc[2] / 9);
            res.alpha = 8'(acc[3] / 9);
            res.row = 12'(r);
            res.col = 11'(c);
            res.last = 1'b0;
            res.done = 1'b0;
            return res;
        endfunction

        function void note_pixel(logic [31:0] pix);
            int unsigned w, h, c, r;
            logic [31:0] up, mid;
            logic lc, lr;
            blur_res_t batch[$];
            w = width_reg < 2 ? 2 : (width_reg > 2048 ? 2048 : width_reg);
            h = height_reg < 2 ? 2 : height_reg;
            c = col_pos >= w ? w - 1 : col_pos;
            r = row_pos >= h ? h - 1 : row_pos;
            if (c == 0) foreach (win[i]) win[i] = '0;
            up = r >= 2 ? upper_mem[c] : '0;
            mid = r >= 1 ? middle_mem[c] : '0;
            for (int i = 0; i < 6; i++) win[i] = win[i+3];
            win[6] = up;
            win[7] = mid;
            win[8] = pix;
            upper_mem[c] = mid;
            middle_mem[c] = pix;
            lc = (c == w - 1);
            lr = (r == h - 1);
            if (r >= 1) begin
                if (c >= 1) batch.push_back(window_sum(7, 7, r - 1, c - 1));
                if (lc) batch.push_back(window_sum(6, 7, r - 1, c));
            end
            if (lr) begin
                if (c >= 1) batch.push_back(window_sum(7, 6, r, c - 1));
                if (lc) batch.push_back(window_sum(6, 6, r, c));
            end
            if (batch.size() > 0) begin
                batch[batch.size()-1].last = 1'b1;
                batch[batch.size()-1].done = lr && lc;
            end
            foreach (batch[i]) pending.push_back(batch[i]);
            if (lc) begin
                col_pos = 0;
                row_pos = lr ? 0 : r + 1;
            end else begin
                col_pos = c + 1;
                row_pos = r;
            end
        endfunction

        function void check_result(blur_res_t got);
            blur_res_t exp;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result row %0d col %0d", got.row, got.col);
                return;
            end
            exp = pending.pop_front();
            if (got !== exp) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp rgba %h %h %h %h r%0d c%0d l%b d%b, got rgba %h %h %h %h r%0d c%0d l%b d%b",
                        exp.red, exp.green, exp.blue, exp.alpha, exp.row, exp.col, exp.last, exp.done,
                        got.red, got.green, got.blue, got.alpha, got.row, got.col, got.last, got.done);
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  pix_red = '0, pix_green = '0, pix_blue = '0, pix_alpha = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  out_red, out_green, out_blue, out_alpha;
    logic [11:0] out_row;
    logic [10:0] out_col;
    logic        run_last, frame_done;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [11:0] cfg_data = '0;

    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    int unsigned cycle_cnt = 0;
    blur_scoreboard sb;

    box_blur_3x3_rgba DUT (.*);

    always #5 clk = ~clk;

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > 1500000) begin
            $display("box_blur_3x3_rgba verification failed");
            $finish;
        end
    end

    // sink: check accepted results, then choose stall for the next cycle
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result({out_red, out_green, out_blue, out_alpha, out_row, out_col,
                             run_last, frame_done});
        out_stall <= ($urandom_range(99) < snk_idle_pct);
    end

    // in_valid stays high after a transaction until the next idle cycle or a drain
    task automatic send_pixel(logic [31:0] pix);
        while ($urandom_range(99) < src_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        {pix_alpha, pix_blue, pix_green, pix_red} <= pix;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_pixel(pix);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic write_cfg(logic [1:0] idx, logic [11:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.write_reg(idx, val);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_frame(int w, int h);
        drain();
        write_cfg(bb3_pkg::REG_WIDTH, 12'(w));
        write_cfg(bb3_pkg::REG_HEIGHT, 12'(h));
    endtask

    function automatic logic [31:0] rand_pix();
        case ($urandom_range(3))
            0: return 32'hFFFFFFFF;
            1: return '0;
            default: return $urandom;
        endcase
    endfunction

    task automatic random_frames(int n);
        int w, h, n_pix;
        for (int k = 0; k < n; k++) begin
            case ($urandom_range(9))
                0: begin w = 2; h = 2; end
                1: begin w = 2048; h = 2; end
                2: begin w = $urandom_range(2, 5); h = 4095; end
                default: begin w = $urandom_range(2, 9); h = $urandom_range(2, 7); end
            endcase
            set_frame(w, h);
            // mostly whole frames, sometimes with extra pixels into the next frame; tall and wide ones are cut
            if (h == 4095 || w == 2048)
                n_pix = 40;
            else
                n_pix = w * h + ($urandom_range(3) == 0 ? $urandom_range(w * h) : 0);
            for (int i = 0; i < n_pix; i++)
                send_pixel(rand_pix());
        end
    endtask

    initial begin
        sb = new();
        sb.reset_state();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // directed: default size, extremes, out-of-range and ignored writes
        for (int i = 0; i < 4; i++) send_pixel(i[0] ? 32'hFFFFFFFF : 32'h0);
        set_frame(3, 3);
        for (int i = 0; i < 9; i++) send_pixel(32'hFFFFFFFF);
        drain();
        write_cfg(2'd3, 12'hFFF);
        write_cfg(2'd2, 12'h0);
        write_cfg(bb3_pkg::REG_WIDTH, 12'd0);
        write_cfg(bb3_pkg::REG_HEIGHT, 12'd1);
        for (int i = 0; i < 5; i++) send_pixel($urandom);
        set_frame(12'hFFF, 12'hFFF);
        for (int i = 0; i < 3; i++) send_pixel(32'hFFFFFFFF);
        src_idle_pct = 14;
        snk_idle_pct = 75;
        random_frames(4);
        src_idle_pct = 75;
        snk_idle_pct = 14;
        random_frames(4);
        src_idle_pct = 0;
        snk_idle_pct = 0;
        random_frames(4);
        drain();
        if (sb.mismatches == 0)
            $display("box_blur_3x3_rgba verification clean");
        else
            $display("box_blur_3x3_rgba verification failed");
        $finish;
    end
endmodule
